// ----- src/ntseq_pkg.sv -----
// Shared constants and types of the multi-track note sequencer.
`default_nettype none
package ntseq_pkg;

  localparam int MAX_TRACKS = 4;
  localparam int MAX_SONGS  = 2;

  localparam int TRACKS_DEF          = 4;
  localparam int NOTES_PER_TRACK_DEF = 256;
  localparam int SONGS_DEF           = 2;

  localparam int TIME_W    = 24;
  localparam int FREQ_W    = 16;
  localparam int LEN_W     = 9;
  localparam int NIDX_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_REGS  = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  typedef logic [MAX_SONGS-1:0][MAX_TRACKS-1:0][LEN_W-1:0] len_bank_t;

  typedef struct packed {
    logic [MAX_TRACKS-1:0][FREQ_W-1:0] tone;
    logic                              restarted;
  } res_t;

endpackage
`default_nettype wire

// ----- src/ntseq_store.sv -----
// Note time and note frequency memories, one port each, registered read.
`default_nettype none
module ntseq_store #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [ADDR_W-1:0]             taddr,
  input  wire logic [ADDR_W-1:0]             faddr,
  input  wire logic [ntseq_pkg::TIME_W-1:0]  wtime,
  input  wire logic [ntseq_pkg::FREQ_W-1:0]  wfreq,
  output logic      [ntseq_pkg::TIME_W-1:0]  rtime,
  output logic      [ntseq_pkg::FREQ_W-1:0]  rfreq
);

  logic [ntseq_pkg::TIME_W-1:0] tmem [DEPTH];
  logic [ntseq_pkg::FREQ_W-1:0] fmem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      tmem[taddr] <= wtime;
      fmem[faddr] <= wfreq;
    end
    rtime <= tmem[taddr];
    rfreq <= fmem[faddr];
  end

endmodule
`default_nettype wire

// ----- src/ntseq_ctrl.sv -----
// Sequencer control: per-track state, song timing and note memory access.
`default_nettype none
module ntseq_ctrl #(
  parameter int TRACKS          = ntseq_pkg::TRACKS_DEF,
  parameter int NOTES_PER_TRACK = ntseq_pkg::NOTES_PER_TRACK_DEF,
  parameter int SONGS           = ntseq_pkg::SONGS_DEF,
  parameter int ADDR_W          = 11
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       action,
  input  wire logic                             song,
  input  wire logic [1:0]                       track,
  input  wire logic [ntseq_pkg::NIDX_W-1:0]     note_index,
  input  wire logic [ntseq_pkg::TIME_W-1:0]     note_time,
  input  wire logic [ntseq_pkg::FREQ_W-1:0]     note_freq,
  input  wire ntseq_pkg::len_bank_t             lens,
  output logic                                  mem_we,
  output logic      [ADDR_W-1:0]                mem_taddr,
  output logic      [ADDR_W-1:0]                mem_faddr,
  output logic      [ntseq_pkg::TIME_W-1:0]     mem_wtime,
  output logic      [ntseq_pkg::FREQ_W-1:0]     mem_wfreq,
  input  wire logic [ntseq_pkg::TIME_W-1:0]     mem_rtime,
  input  wire logic [ntseq_pkg::FREQ_W-1:0]     mem_rfreq,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ntseq_pkg::res_t                       out_res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_ST0  = 4'd2;
  localparam logic [3:0] S_ST1  = 4'd3;
  localparam logic [3:0] S_ST2  = 4'd4;
  localparam logic [3:0] S_TK0  = 4'd5;
  localparam logic [3:0] S_TK1  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  localparam logic [1:0] TRK_LAST = 2'(TRACKS - 1);
  localparam int LW = ntseq_pkg::LEN_W;
  localparam int TW = ntseq_pkg::TIME_W;
  localparam int FW = ntseq_pkg::FREQ_W;

  localparam ntseq_pkg::res_t RES_RESTART = '{tone: '0, restarted: 1'b1};

  function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] v);
    if (v == '0) begin
      return LW'(1);
    end else if (32'(v) > NOTES_PER_TRACK) begin
      return LW'(NOTES_PER_TRACK);
    end else begin
      return v;
    end
  endfunction

  logic [3:0]                      state;
  logic [1:0]                      trk;
  logic [1:0]                      op_action;
  logic                            op_song;
  logic [1:0]                      op_track;
  logic [ntseq_pkg::NIDX_W-1:0]    op_idx;
  logic [TW-1:0]                   op_time;
  logic [FW-1:0]                   op_freq;
  logic                            active_song;
  logic                            playing;
  logic [TW-1:0]                   elapsed;
  logic [TW-1:0]                   song_length;
  logic [TW-1:0]                   len_acc;
  logic [LW-1:0]                   pos       [ntseq_pkg::MAX_TRACKS];
  logic [TW-1:0]                   next_time [ntseq_pkg::MAX_TRACKS];
  logic [FW-1:0]                   cur_freq  [ntseq_pkg::MAX_TRACKS];
  logic [LW-1:0]                   latched   [ntseq_pkg::MAX_TRACKS];
  ntseq_pkg::res_t                 res_work;
  ntseq_pkg::res_t                 tick_res;

  logic [LW-1:0]     cur_len;
  logic [ADDR_W-1:0] track_base;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic [TW-1:0]     elapsed_inc;
  logic [LW-1:0]     pos_inc;
  logic              advance;
  logic [TW-1:0]     len_min;

  assign cur_len    = clamp_len(lens[active_song][trk]);
  assign track_base = ADDR_W'((32'(active_song) * TRACKS + 32'(trk)) * NOTES_PER_TRACK);
  assign wr_addr    = ADDR_W'((32'(op_song) * TRACKS + 32'(op_track)) * NOTES_PER_TRACK
                              + 32'(op_idx));
  assign wr_ok      = (32'(op_song) < SONGS) && (32'(op_track) < TRACKS)
                      && (32'(op_idx) < NOTES_PER_TRACK);
  assign elapsed_inc = (elapsed == ntseq_pkg::TIME_MAX) ? elapsed : elapsed + TW'(1);
  assign pos_inc    = pos[trk] + LW'(1);
  assign advance    = (pos[trk] < latched[trk]) && (elapsed >= next_time[trk]);
  assign len_min    = (mem_rtime < len_acc) ? mem_rtime : len_acc;

  assign in_stall  = (state != S_IDLE);
  assign mem_wtime = op_time;
  assign mem_wfreq = op_freq;

  always_comb begin
    tick_res = '0;
    for (int t = 0; t < ntseq_pkg::MAX_TRACKS; t++) begin
      if (t < TRACKS && pos[t] < latched[t]) begin
        tick_res.tone[t] = cur_freq[t];
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_taddr = wr_addr;
    mem_faddr = wr_addr;
    case (state)
      S_DISP: begin
        mem_we = (op_action == ntseq_pkg::ACT_WRITE) && wr_ok;
      end
      S_ST0: begin
        mem_taddr = track_base;
        mem_faddr = track_base;
      end
      S_ST1: begin
        mem_taddr = track_base + ADDR_W'(cur_len - LW'(1));
        mem_faddr = track_base;
      end
      S_TK0: begin
        mem_faddr = track_base + ADDR_W'(pos[trk]);
        mem_taddr = track_base + ADDR_W'(pos_inc);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      trk         <= '0;
      out_valid   <= 1'b0;
      active_song <= 1'b0;
      playing     <= 1'b0;
      elapsed     <= '0;
      song_length <= ntseq_pkg::TIME_MAX;
      for (int t = 0; t < ntseq_pkg::MAX_TRACKS; t++) begin
        pos[t]       <= '0;
        next_time[t] <= '0;
        cur_freq[t]  <= '0;
        latched[t]   <= LW'(1);
      end
    end else begin
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_action <= action;
            op_song   <= song;
            op_track  <= track;
            op_idx    <= note_index;
            op_time   <= note_time;
            op_freq   <= note_freq;
            state     <= S_DISP;
          end
        end
        S_DISP: begin
          trk     <= '0;
          len_acc <= ntseq_pkg::TIME_MAX;
          case (op_action)
            ntseq_pkg::ACT_START: begin
              res_work <= '0;
              if (32'(op_song) < SONGS) begin
                active_song <= op_song;
              end
              state <= S_ST0;
            end
            ntseq_pkg::ACT_TICK: begin
              if (playing && elapsed_inc >= song_length) begin
                res_work <= RES_RESTART;
                state    <= S_ST0;
              end else if (playing) begin
                res_work <= tick_res;
                elapsed  <= elapsed_inc;
                state    <= S_TK0;
              end else begin
                res_work <= '0;
                state    <= S_FIN;
              end
            end
            default: begin
              res_work <= '0;
              state    <= S_FIN;
            end
          endcase
        end
        S_ST0: begin
          state <= S_ST1;
        end
        S_ST1: begin
          next_time[trk] <= mem_rtime;
          cur_freq[trk]  <= (mem_rtime != '0) ? '0 : mem_rfreq;
          latched[trk]   <= cur_len;
          pos[trk]       <= '0;
          state          <= S_ST2;
        end
        S_ST2: begin
          if (trk == TRK_LAST) begin
            song_length <= len_min;
            elapsed     <= '0;
            playing     <= 1'b1;
            state       <= S_FIN;
          end else begin
            len_acc <= len_min;
            trk     <= trk + 2'd1;
            state   <= S_ST0;
          end
        end
        S_TK0: begin
          if (advance) begin
            pos[trk] <= pos_inc;
          end
          if (advance && pos_inc < latched[trk]) begin
            state <= S_TK1;
          end else if (trk == TRK_LAST) begin
            state <= S_FIN;
          end else begin
            trk <= trk + 2'd1;
          end
        end
        S_TK1: begin
          cur_freq[trk]  <= mem_rfreq;
          next_time[trk] <= mem_rtime;
          if (trk == TRK_LAST) begin
            state <= S_FIN;
          end else begin
            trk   <= trk + 2'd1;
            state <= S_TK0;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_res <= res_work;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result appeared outside the finish step");

  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.restarted |-> out_res.tone == '0)
    else $error("tones present on a restart result");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    playing |-> elapsed <= song_length)
    else $error("elapsed time beyond song length");

  a_idle_clock: assert property (@(posedge clk) disable iff (rst)
    !playing |-> elapsed == '0)
    else $error("elapsed time moved before any start");

endmodule
`default_nettype wire

// ----- src/multi_track_note_sequencer_unit.sv -----
// Top level of the multi-track note sequencer: configuration registers and wiring.
//
// Input channel (in_valid/in_stall) carries one item per transfer: a tick, a note
// write or a song start. Each accepted item yields exactly one result on the output
// channel (out_valid/out_stall): four track tones and a restart flag; writes, starts
// and unused actions give an all-zero result.
// A write or ignored item passes through dispatch and finish; a tick visits each
// track in turn, with an extra step for each track that moves on to a new note; a
// start (or a tick that restarts the song) reads the first and last note of each
// track in turn. Each note memory has one port, which all these note reads share.
// The next item is taken once the result sits in the output register, even if the
// receiver stalls it; a stalled result holds its value, and the block then waits
// before loading the following one.
// Track lengths are written through cfg_write/cfg_index/cfg_data while idle; that
// is the user's duty, which the block itself leaves unenforced. Reset clears
// playback (silence until the first start) and sets all lengths to 1; note
// memories hold no defined contents until written.
`default_nettype none
module multi_track_note_sequencer_unit #(
  parameter int TRACKS          = ntseq_pkg::TRACKS_DEF,
  parameter int NOTES_PER_TRACK = ntseq_pkg::NOTES_PER_TRACK_DEF,
  parameter int SONGS           = ntseq_pkg::SONGS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ntseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ntseq_pkg::LEN_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        action,
  input  wire logic                              song,
  input  wire logic [1:0]                        track,
  input  wire logic [ntseq_pkg::NIDX_W-1:0]      note_index,
  input  wire logic [ntseq_pkg::TIME_W-1:0]      note_time,
  input  wire logic [ntseq_pkg::FREQ_W-1:0]      note_freq,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ntseq_pkg::FREQ_W-1:0]      tone_track0,
  output logic      [ntseq_pkg::FREQ_W-1:0]      tone_track1,
  output logic      [ntseq_pkg::FREQ_W-1:0]      tone_track2,
  output logic      [ntseq_pkg::FREQ_W-1:0]      tone_track3,
  output logic                                   song_restarted
);

  localparam int DEPTH  = SONGS * TRACKS * NOTES_PER_TRACK;
  localparam int ADDR_W = $clog2(DEPTH);

  ntseq_pkg::len_bank_t           lens;
  ntseq_pkg::res_t                out_res;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_taddr;
  logic [ADDR_W-1:0]              mem_faddr;
  logic [ntseq_pkg::TIME_W-1:0]   mem_wtime;
  logic [ntseq_pkg::FREQ_W-1:0]   mem_wfreq;
  logic [ntseq_pkg::TIME_W-1:0]   mem_rtime;
  logic [ntseq_pkg::FREQ_W-1:0]   mem_rfreq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ntseq_pkg::MAX_SONGS; s++) begin
        for (int t = 0; t < ntseq_pkg::MAX_TRACKS; t++) begin
          lens[s][t] <= ntseq_pkg::LEN_W'(1);
        end
      end
    end else if (cfg_write && cfg_index < ntseq_pkg::CFG_IDX_W'(ntseq_pkg::NUM_REGS)) begin
      lens[cfg_index[2]][cfg_index[1:0]] <= cfg_data;
    end
  end

  ntseq_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .taddr (mem_taddr),
    .faddr (mem_faddr),
    .wtime (mem_wtime),
    .wfreq (mem_wfreq),
    .rtime (mem_rtime),
    .rfreq (mem_rfreq)
  );

  ntseq_ctrl #(
    .TRACKS          (TRACKS),
    .NOTES_PER_TRACK (NOTES_PER_TRACK),
    .SONGS           (SONGS),
    .ADDR_W          (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .song       (song),
    .track      (track),
    .note_index (note_index),
    .note_time  (note_time),
    .note_freq  (note_freq),
    .lens       (lens),
    .mem_we     (mem_we),
    .mem_taddr  (mem_taddr),
    .mem_faddr  (mem_faddr),
    .mem_wtime  (mem_wtime),
    .mem_wfreq  (mem_wfreq),
    .mem_rtime  (mem_rtime),
    .mem_rfreq  (mem_rfreq),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign tone_track0    = out_res.tone[0];
  assign tone_track1    = out_res.tone[1];
  assign tone_track2    = out_res.tone[2];
  assign tone_track3    = out_res.tone[3];
  assign song_restarted = out_res.restarted;

endmodule
`default_nettype wire
